/* rtl/slpe_pkg.sv */
// status led pattern engine: shared types, constants and hsv helper functions
// no dependencies; imported by every other file of the block
package slpe_pkg;

    localparam int TIME_BITS = 40;
    localparam int PAT_W     = 3;
    localparam int PERIOD_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = ((PAT_W + TIME_BITS + 7) / 8) * 8;
    localparam int M_DATA_W  = 32;

    localparam logic [PAT_W-1:0] PAT_OFF     = 3'd0;
    localparam logic [PAT_W-1:0] PAT_SOLID   = 3'd1;
    localparam logic [PAT_W-1:0] PAT_BREATH  = 3'd2;
    localparam logic [PAT_W-1:0] PAT_PAIRING = 3'd3;
    localparam logic [PAT_W-1:0] PAT_ERROR   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_USE_RGB     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd120000;

    localparam logic [7:0] BRIGHT_PEAK  = 8'd64;
    localparam logic [7:0] BRIGHT_FLOOR = 8'd4;
    localparam logic [7:0] BRIGHT_INCR  = 8'd2;

    localparam logic [2:0] HSV_LAST_STEP = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HSV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                use_rgb;
        logic                active_high;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic                 command;
        logic [PAT_W-1:0]     pattern;
        logic [TIME_BITS-1:0] now_us;
    } t_item;

    typedef struct packed {
        logic       lit;
        logic       pin_level;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_res;

    // plain on/off write: fixed colour on the pixel or polarity on the pin
    function automatic t_res drive_res(input logic on, input t_cfg cfg);
        t_res res;
        res = '0;
        if (cfg.use_rgb) begin
            if (on) begin
                res.red   = 8'd16;
                res.green = 8'd64;
                res.blue  = 8'd255;
                res.lit   = 1'b1;
            end
        end else begin
            res.pin_level = on ? cfg.active_high : ~cfg.active_high;
            res.lit       = on;
        end
        return res;
    endfunction

    // hue sector, each 43 wide but the last, which is 41 wide
    function automatic logic [2:0] hsv_region(input logic [7:0] h);
        logic [2:0] region;
        if (h < 8'd43)       region = 3'd0;
        else if (h < 8'd86)  region = 3'd1;
        else if (h < 8'd129) region = 3'd2;
        else if (h < 8'd172) region = 3'd3;
        else if (h < 8'd215) region = 3'd4;
        else                 region = 3'd5;
        return region;
    endfunction

    // offset inside the sector scaled by 6
    function automatic logic [7:0] hsv_rem(input logic [7:0] h, input logic [2:0] region);
        logic [7:0] base;
        logic [7:0] diff;
        case (region)
            3'd0:    base = 8'd0;
            3'd1:    base = 8'd43;
            3'd2:    base = 8'd86;
            3'd3:    base = 8'd129;
            3'd4:    base = 8'd172;
            default: base = 8'd215;
        endcase
        diff = h - base;
        return 8'((diff << 2) + (diff << 1));
    endfunction

endpackage

/* rtl/slpe_mul.sv */
// shared 8x8 multiplier with registered product
// depends on slpe_pkg (imported for house consistency)
module slpe_mul (
    input  logic        i_clk,
    input  logic [7:0]  i_a,
    input  logic [7:0]  i_b,
    output logic [15:0] o_prod
);
    import slpe_pkg::*;

    logic [15:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 16'(i_a) * 16'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* rtl/slpe_ctrl.sv */
// pattern sequencer: item capture, pattern state and the hsv steps on the shared multiplier
// depends on slpe_pkg and slpe_mul
module slpe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  slpe_pkg::t_cfg  i_cfg,
    input  logic           i_item_valid,
    input  slpe_pkg::t_item i_item,
    output logic           o_item_ready,
    output logic           o_res_valid,
    output slpe_pkg::t_res  o_res,
    input  logic           i_res_ready
);
    import slpe_pkg::*;

    t_state r_state, n_state;
    t_item  r_item;

    logic [PAT_W-1:0]     r_pattern, n_pattern;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [7:0]           r_bright, n_bright;
    logic                 r_rising, n_rising;
    logic [7:0]           r_hue, n_hue;
    logic                 r_phase, n_phase;
    logic                 r_pin, n_pin;
    logic                 r_has, n_has;
    logic [2:0]           r_step, n_step;
    t_res                 r_res, n_res;
    logic [7:0]           r_k0, n_k0;
    logic [7:0]           r_k1, n_k1;
    logic [7:0]           r_q, n_q;

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_due;
    logic [7:0]           w_nb;
    logic [2:0]           w_region;
    logic [7:0]           w_rem;
    logic [7:0]           w_mul_a;
    logic [7:0]           w_mul_b;
    logic [15:0]          w_prod;
    logic [7:0]           w_hi;
    logic                 w_go_hsv;
    t_res                 w_hsv;

    slpe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_elapsed = r_item.now_us - r_last;
    assign w_due     = w_elapsed >= TIME_BITS'(i_cfg.period);
    assign w_nb      = r_rising ? r_bright + BRIGHT_INCR : r_bright - BRIGHT_INCR;
    assign w_region  = hsv_region(r_hue);
    assign w_rem     = hsv_rem(r_hue, w_region);
    assign w_hi      = w_prod[15:8];
    assign w_go_hsv  = !r_item.command && r_pattern == PAT_BREATH && i_cfg.use_rgb;

    // operand select per step; product of step k shows up at step k+1
    always_comb begin
        w_mul_a = 8'd255;
        w_mul_b = 8'd0;
        case (r_step)
            3'd0:    w_mul_b = w_rem;
            3'd1:    w_mul_b = ~w_rem;
            3'd2: begin
                w_mul_a = r_bright;
                w_mul_b = ~r_k0;
            end
            3'd3: begin
                w_mul_a = r_bright;
                w_mul_b = ~r_k1;
            end
            default: w_mul_b = 8'd0;
        endcase
    end

    // sector to channel mapping, t comes straight off the multiplier on the last step
    always_comb begin
        w_hsv     = '0;
        w_hsv.lit = 1'b1;
        case (w_region)
            3'd0: begin
                w_hsv.red = r_bright; w_hsv.green = w_hi;
            end
            3'd1: begin
                w_hsv.red = r_q; w_hsv.green = r_bright;
            end
            3'd2: begin
                w_hsv.green = r_bright; w_hsv.blue = w_hi;
            end
            3'd3: begin
                w_hsv.green = r_q; w_hsv.blue = r_bright;
            end
            3'd4: begin
                w_hsv.red = w_hi; w_hsv.blue = r_bright;
            end
            default: begin
                w_hsv.red = r_bright; w_hsv.blue = r_q;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_item_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = w_go_hsv ? ST_HSV : ST_DONE;
            ST_HSV:  if (r_step == HSV_LAST_STEP) n_state = ST_DONE;
            ST_DONE: if (!r_has || i_res_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = r_state == ST_IDLE;
        o_res_valid  = r_state == ST_DONE && r_has;
        o_res        = r_res;
    end

    always_comb begin
        n_pattern = r_pattern;
        n_last    = r_last;
        n_bright  = r_bright;
        n_rising  = r_rising;
        n_hue     = r_hue;
        n_phase   = r_phase;
        n_pin     = r_pin;
        n_has     = r_has;
        n_step    = r_step;
        n_res     = r_res;
        n_k0      = r_k0;
        n_k1      = r_k1;
        n_q       = r_q;
        unique case (r_state)
            ST_EXEC: begin
                n_has  = 1'b0;
                n_step = 3'd0;
                if (r_item.command) begin
                    n_pattern = r_item.pattern;
                    n_last    = r_item.now_us;
                end else begin
                    unique case (r_pattern)
                        PAT_OFF: begin
                            n_res = drive_res(1'b0, i_cfg);
                            n_pin = 1'b0;
                            n_has = 1'b1;
                        end
                        PAT_SOLID: begin
                            n_res = drive_res(1'b1, i_cfg);
                            n_pin = 1'b1;
                            n_has = 1'b1;
                        end
                        PAT_ERROR: begin
                            n_has = 1'b1;
                            if (i_cfg.use_rgb) begin
                                n_res       = '0;
                                n_res.red   = 8'd64;
                                n_res.lit   = 1'b1;
                            end else begin
                                n_res = drive_res(1'b1, i_cfg);
                                n_pin = 1'b1;
                            end
                        end
                        PAT_BREATH: begin
                            if (i_cfg.use_rgb) begin
                                if (w_nb >= BRIGHT_PEAK) begin
                                    n_bright = BRIGHT_PEAK;
                                    n_rising = 1'b0;
                                end else if (w_nb <= BRIGHT_FLOOR) begin
                                    n_bright = BRIGHT_FLOOR;
                                    n_rising = 1'b1;
                                end else begin
                                    n_bright = w_nb;
                                end
                                n_hue = r_hue + 8'd1;
                            end else begin
                                n_res = drive_res(1'b1, i_cfg);
                                n_pin = 1'b1;
                                n_has = 1'b1;
                            end
                        end
                        PAT_PAIRING: begin
                            if (w_due) begin
                                n_has  = 1'b1;
                                n_last = r_item.now_us;
                                if (i_cfg.use_rgb) begin
                                    n_phase = ~r_phase;
                                    n_res   = '0;
                                    if (!r_phase) begin
                                        n_res.red   = 8'd64;
                                        n_res.green = 8'd64;
                                        n_res.blue  = 8'd64;
                                        n_res.lit   = 1'b1;
                                    end
                                end else begin
                                    n_res = drive_res(~r_pin, i_cfg);
                                    n_pin = ~r_pin;
                                end
                            end
                        end
                        default: n_has = 1'b0;
                    endcase
                end
            end
            ST_HSV: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd1: n_k0 = w_hi;
                    3'd2: n_k1 = w_hi;
                    3'd3: n_q  = w_hi;
                    3'd4: begin
                        n_res = w_hsv;
                        n_has = 1'b1;
                    end
                    default: n_step = r_step + 3'd1;
                endcase
            end
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pattern <= PAT_OFF;
            r_last    <= '0;
            r_bright  <= '0;
            r_rising  <= 1'b1;
            r_hue     <= '0;
            r_phase   <= 1'b0;
            r_pin     <= 1'b0;
            r_has     <= 1'b0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_pattern <= n_pattern;
            r_last    <= n_last;
            r_bright  <= n_bright;
            r_rising  <= n_rising;
            r_hue     <= n_hue;
            r_phase   <= n_phase;
            r_pin     <= n_pin;
            r_has     <= n_has;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_item_valid) begin
            r_item <= i_item;
        end
        r_res <= n_res;
        r_k0  <= n_k0;
        r_k1  <= n_k1;
        r_q   <= n_q;
    end

endmodule

/* rtl/status_led_pattern_engine_unit.sv */
// from accept to the output register a tick passes the exec and done states; breathing
// ticks in pixel mode also pass the hsv steps, four passes through the one 8x8 multiplier.
// one transaction is in work at a time, and a result waiting in the output register does
// not block the next input transaction, a second finished one holds the sequencer.
// synchronous active-low reset: pattern off, breathing state cleared, config to defaults.
module status_led_pattern_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [slpe_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [slpe_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pattern[2:0], now_us[42:3], zero fill
    input  logic [slpe_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], pin_level[24], lit[25], zero fill
    output logic [slpe_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import slpe_pkg::*;

    t_cfg  r_cfg;
    t_item w_item;
    t_res  w_res;
    logic  w_res_valid;
    logic  w_res_ready;
    logic  r_out_valid;
    t_res  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_rgb     <= 1'b1;
            r_cfg.active_high <= 1'b1;
            r_cfg.period      <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_USE_RGB:     r_cfg.use_rgb     <= i_cfg_wdata[0];
                REG_ACTIVE_HIGH: r_cfg.active_high <= i_cfg_wdata[0];
                REG_PERIOD:      r_cfg.period      <= i_cfg_wdata;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign w_item.command = s_axis_tuser;
    assign w_item.pattern = s_axis_tdata[PAT_W-1:0];
    assign w_item.now_us  = s_axis_tdata[PAT_W +: TIME_BITS];

    slpe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (s_axis_tvalid),
        .i_item       (w_item),
        .o_item_ready (s_axis_tready),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_ready  (w_res_ready)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'(r_out);

endmodule

/* rtl/slpe_checker.sv */
// port-level checks for the status led pattern engine, bound to the top level
// depends on slpe_pkg and status_led_pattern_engine_unit
module slpe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [slpe_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import slpe_pkg::*;

    // output register is cleared by reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a dark write never carries colour
    a_dark_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[25] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("colour on a dark write");

    // pin level and colour are never driven together
    a_pin_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("pin level with colour");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind status_led_pattern_engine_unit slpe_checker u_slpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/status_led_pattern_engine_unit_tb.sv */
// self-checking bench for the status led pattern engine: directed table, then random phases
// under several register settings, every result checked against an in-bench model or a fixed table value
// depends on rtl/slpe_pkg.sv and rtl/status_led_pattern_engine_unit.sv
`timescale 1ns / 100ps

module status_led_pattern_engine_unit_tb;
    import slpe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 80;
    localparam int HUE_SECTOR    = 43;

    // pattern codes the block stores but never acts on
    localparam logic [PAT_W-1:0] PAT_SPARE_A = 3'd5;
    localparam logic [PAT_W-1:0] PAT_SPARE_B = 3'd6;
    localparam logic [PAT_W-1:0] PAT_SPARE_C = 3'd7;

    localparam logic [TIME_BITS-1:0] NOW_MAX = '1;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_FIXED
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic                 cmd;
        logic [PAT_W-1:0]     pat;
        logic [TIME_BITS-1:0] now;
        t_res                 fixed;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = REG_USE_RGB;
    logic [PERIOD_W-1:0]   i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    status_led_pattern_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of the block's registers and pattern state
    t_cfg                 cfg_shadow;
    logic [PAT_W-1:0]     sel_pattern;
    logic [7:0]           breath_level;
    logic                 breath_up;
    logic [7:0]           hue_step;
    logic                 blink_on;
    logic                 pin_on;
    logic [TIME_BITS-1:0] toggle_mark_us;

    t_res      expected_writes[$];
    t_stim_row directed_rows[$];

    logic [TIME_BITS-1:0] wall_us;
    int  n_sent;
    int  n_selects;
    int  n_checked;
    int  n_fail;
    int  cycle_count;
    bit  quiet_tail;
    bit  long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // plain on/off write, fixed colour on the pixel or polarity on the pin
    function automatic t_res plain_write(input logic on);
        t_res res;
        res = '0;
        if (cfg_shadow.use_rgb) begin
            if (on) begin
                res.red   = 8'd16;
                res.green = 8'd64;
                res.blue  = 8'd255;
                res.lit   = 1'b1;
            end
        end else begin
            res.pin_level = on ? cfg_shadow.active_high : ~cfg_shadow.active_high;
            res.lit       = on;
        end
        pin_on = on;
        return res;
    endfunction

    // integer hsv to rgb at full saturation, so the p term is always zero
    function automatic t_res hsv_color(input logic [7:0] h, input logic [7:0] v);
        t_res        res;
        int unsigned hh;
        int unsigned vv;
        int unsigned region;
        int unsigned rem;
        int unsigned q;
        int unsigned t;
        hh     = 32'(h);
        vv     = 32'(v);
        region = hh / HUE_SECTOR;
        rem    = ((hh - region * HUE_SECTOR) * 6) & 8'hFF;
        q      = ((vv * (255 - ((255 * rem) >> 8))) >> 8) & 8'hFF;
        t      = ((vv * (255 - ((255 * (255 - rem)) >> 8))) >> 8) & 8'hFF;
        res    = '0;
        res.lit = 1'b1;
        case (region)
            0: begin res.red = v;      res.green = 8'(t); end
            1: begin res.red = 8'(q);  res.green = v;     end
            2: begin res.green = v;     res.blue = 8'(t);  end
            3: begin res.green = 8'(q); res.blue = v;      end
            4: begin res.red = 8'(t);  res.blue = v;      end
            default: begin res.red = v; res.blue = 8'(q); end
        endcase
        return res;
    endfunction

    // advances the shadow state by one transaction; returns 1 when a write is due
    function automatic bit next_led_write(input logic cmd, input logic [PAT_W-1:0] pat,
                                          input logic [TIME_BITS-1:0] now, output t_res res);
        logic [TIME_BITS-1:0] elapsed;
        logic [7:0]           nb;
        res = '0;
        if (cmd) begin
            sel_pattern    = pat;
            toggle_mark_us = now;
            return 1'b0;
        end
        case (sel_pattern)
            PAT_OFF: begin
                res = plain_write(1'b0);
                return 1'b1;
            end
            PAT_SOLID: begin
                res = plain_write(1'b1);
                return 1'b1;
            end
            PAT_ERROR: begin
                if (cfg_shadow.use_rgb) begin
                    res.red = 8'd64;
                    res.lit = 1'b1;
                end else begin
                    res = plain_write(1'b1);
                end
                return 1'b1;
            end
            PAT_BREATH: begin
                if (cfg_shadow.use_rgb) begin
                    nb = breath_up ? breath_level + BRIGHT_INCR : breath_level - BRIGHT_INCR;
                    if (nb >= BRIGHT_PEAK) begin
                        nb        = BRIGHT_PEAK;
                        breath_up = 1'b0;
                    end else if (nb <= BRIGHT_FLOOR) begin
                        nb        = BRIGHT_FLOOR;
                        breath_up = 1'b1;
                    end
                    breath_level = nb;
                    hue_step     = hue_step + 8'd1;
                    res          = hsv_color(hue_step, breath_level);
                end else begin
                    res = plain_write(1'b1);
                end
                return 1'b1;
            end
            PAT_PAIRING: begin
                elapsed = now - toggle_mark_us;
                if (elapsed < TIME_BITS'(cfg_shadow.period))
                    return 1'b0;
                if (cfg_shadow.use_rgb) begin
                    blink_on = ~blink_on;
                    if (blink_on) begin
                        res.red   = 8'd64;
                        res.green = 8'd64;
                        res.blue  = 8'd64;
                        res.lit   = 1'b1;
                    end
                end else begin
                    res = plain_write(~pin_on);
                end
                toggle_mark_us = now;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic cmd,
                                    input logic [PAT_W-1:0] pat,
                                    input logic [TIME_BITS-1:0] now,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic pin, input logic lit);
        t_stim_row row;
        row.kind            = kind;
        row.cmd             = cmd;
        row.pat             = pat;
        row.now             = now;
        row.fixed.red       = r;
        row.fixed.green     = g;
        row.fixed.blue      = b;
        row.fixed.pin_level = pin;
        row.fixed.lit       = lit;
        directed_rows.push_back(row);
    endfunction

    // offers one transaction, starting and ending on a falling edge
    task automatic send_item(input logic cmd, input logic [PAT_W-1:0] pat,
                             input logic [TIME_BITS-1:0] now);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= S_DATA_W'({now, pat});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
        if (cmd) n_selects++;
        @(negedge i_clk);
    endtask

    task automatic apply_item(input logic cmd, input logic [PAT_W-1:0] pat,
                              input logic [TIME_BITS-1:0] now);
        t_res res;
        send_item(cmd, pat, now);
        if (next_led_write(cmd, pat, now, res)) expected_writes.push_back(res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    // only touch registers once the block has drained, selects and silent ticks included
    task automatic reconfigure(input logic rgb, input logic ah, input logic [PERIOD_W-1:0] period);
        s_axis_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(REG_USE_RGB, PERIOD_W'(rgb));
        write_reg(REG_ACTIVE_HIGH, PERIOD_W'(ah));
        write_reg(REG_PERIOD, period);
        i_cfg_we <= 1'b0;
        cfg_shadow.use_rgb     = rgb;
        cfg_shadow.active_high = ah;
        cfg_shadow.period      = period;
    endtask

    // mostly short steps, some landing exactly on the toggle period or one short of it, some wild jumps
    function automatic logic [TIME_BITS-1:0] time_step();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)      return TIME_BITS'($urandom_range(0, cfg_shadow.period / 3));
        else if (sel <= 7) return TIME_BITS'(cfg_shadow.period);
        else if (sel == 8) return TIME_BITS'(cfg_shadow.period) - 1;
        else               return TIME_BITS'({$urandom, $urandom});
    endfunction

    task automatic run_random(input int n_items);
        int               sent;
        int               burst;
        int               pick;
        logic [PAT_W-1:0] pat;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      pat = PAT_BREATH;
            else if (pick < 60) pat = PAT_PAIRING;
            else if (pick < 70) pat = PAT_SOLID;
            else if (pick < 80) pat = PAT_ERROR;
            else if (pick < 90) pat = PAT_OFF;
            else                pat = PAT_W'($urandom_range(PAT_SPARE_A, PAT_SPARE_C));
            if ($urandom_range(0, 9) == 0) wall_us = TIME_BITS'({$urandom, $urandom});
            apply_item(1'b1, pat, wall_us);
            sent++;
            burst = $urandom_range(2, 20);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                wall_us = wall_us + time_step();
                // pattern field is don't-care on a tick
                apply_item(1'b0, PAT_W'($urandom), wall_us);
                sent++;
            end
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        int idle_left;
        hold_left = 0;
        idle_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_res)-1:0];
            if (expected_writes.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected led write, expected none, got r=%0d g=%0d b=%0d pin=%0d lit=%0d",
                         $time, got.red, got.green, got.blue, got.pin_level, got.lit);
            end else begin
                want = expected_writes.pop_front();
                check_field("red", 32'(want.red), 32'(got.red));
                check_field("green", 32'(want.green), 32'(got.green));
                check_field("blue", 32'(want.blue), 32'(got.blue));
                check_field("pin_level", 32'(want.pin_level), 32'(got.pin_level));
                check_field("lit", 32'(want.lit), 32'(got.lit));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still pending",
                     cycle_count, expected_writes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_res res;
        bit   due;
        n_sent         = 0;
        n_selects      = 0;
        n_checked      = 0;
        n_fail         = 0;
        cycle_count    = 0;
        quiet_tail     = 1'b0;
        long_hold_req  = 1'b0;
        wall_us        = '0;
        cfg_shadow.use_rgb     = 1'b1;
        cfg_shadow.active_high = 1'b1;
        cfg_shadow.period      = PERIOD_RESET;
        sel_pattern    = PAT_OFF;
        breath_level   = 8'd0;
        breath_up      = 1'b1;
        hue_step       = 8'd0;
        blink_on       = 1'b0;
        pin_on         = 1'b0;
        toggle_mark_us = '0;

        // directed table, run under the reset register values
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     '0,         0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b1, PAT_SOLID,   40'd5,      0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_SPARE_C, NOW_MAX,    16, 64,  255, 0, 1);
        add_row(ROW_SILENT,  1'b1, PAT_ERROR,   NOW_MAX,    0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     40'd9,      64, 0,   0,   0, 1);
        add_row(ROW_SILENT,  1'b1, PAT_BREATH,  '0,         0,  0,   0,   0, 0);
        add_row(ROW_PREDICT, 1'b0, PAT_OFF,     40'd10,     0,  0,   0,   0, 0);
        add_row(ROW_PREDICT, 1'b0, PAT_OFF,     40'd20,     0,  0,   0,   0, 0);
        add_row(ROW_PREDICT, 1'b0, PAT_OFF,     40'd30,     0,  0,   0,   0, 0);
        add_row(ROW_PREDICT, 1'b0, PAT_OFF,     40'd40,     0,  0,   0,   0, 0);
        // pairing: one short of the period, exactly on it, then across the time wrap
        add_row(ROW_SILENT,  1'b1, PAT_PAIRING, 40'd1000,   0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b0, PAT_OFF,     40'd120999, 0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     40'd121000, 64, 64,  64,  0, 1);
        add_row(ROW_SILENT,  1'b0, PAT_OFF,     40'd121001, 0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     40'd241000, 0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b1, PAT_PAIRING, NOW_MAX - 9, 0, 0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b0, PAT_OFF,     40'd119989, 0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     40'd119990, 64, 64,  64,  0, 1);
        // unknown patterns are stored but stay silent
        add_row(ROW_SILENT,  1'b1, PAT_SPARE_A, 40'd7,      0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b0, PAT_OFF,     40'd8,      0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b1, PAT_SPARE_B, 40'd9,      0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b0, PAT_OFF,     40'd10,     0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b1, PAT_SPARE_C, 40'd11,     0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b0, PAT_SPARE_C, NOW_MAX,    0,  0,   0,   0, 0);
        add_row(ROW_SILENT,  1'b1, PAT_OFF,     40'd12,     0,  0,   0,   0, 0);
        add_row(ROW_FIXED,   1'b0, PAT_OFF,     40'd13,     0,  0,   0,   0, 0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].pat, directed_rows[i].now);
            due = next_led_write(directed_rows[i].cmd, directed_rows[i].pat,
                                 directed_rows[i].now, res);
            case (directed_rows[i].kind)
                ROW_PREDICT: if (due) expected_writes.push_back(res);
                ROW_FIXED:   expected_writes.push_back(directed_rows[i].fixed);
                default:     ;
            endcase
        end

        reconfigure(1'b1, 1'b0, 24'd1);
        run_random(120);
        reconfigure(1'b0, 1'b1, '1);
        run_random(60);
        // zero period makes pairing toggle on every tick
        reconfigure(1'b0, 1'b0, '0);
        run_random(60);
        reconfigure(1'b1, 1'b1, PERIOD_W'($urandom_range(1, 300000)));
        long_hold_req = 1'b1;
        run_random(120);
        reconfigure(1'b0, 1'b1, PERIOD_RESET);
        run_random(60);
        reconfigure(1'b1, 1'b0, PERIOD_W'($urandom_range(1, 300000)));
        quiet_tail = 1'b1;
        run_random(120);

        s_axis_tvalid <= 1'b0;
        while (expected_writes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d transactions sent (%0d pattern selects), %0d led writes checked",
                 n_sent, n_selects, n_checked);
        $display("covered pixel and pin modes, both polarities, periods 0, 1, max and random");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
